// ===== hdl/rcmm_ir_frame_decoder_unit_macros.svh =====
// Assertion macros for the decoder unit.
`ifndef RCMM_IR_FRAME_DECODER_UNIT_MACROS_SVH
`define RCMM_IR_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define RCMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rcmm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RCMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rcmm assertion failed");

`else

`define RCMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RCMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/rcmm_pkg.sv =====
package rcmm_pkg;

	// Frame geometry
	localparam int FRAME_BITS = 32;
	localparam int PAIRS      = FRAME_BITS / 2;
	localparam int STOP_IDX   = 2 + 2 * PAIRS;
	localparam int POS_W      = $clog2(STOP_IDX + 1);
	localparam int VALUE_W    = 32;
	localparam int TICK_W     = 16;

	// Configuration register widths and indexes
	localparam int TOL_W = 6;
	localparam int EX_W  = 8;
	localparam int UPT_W = 8;
	localparam int CIDX_W = 2;
	localparam int CDATA_W = 8;
	localparam logic [CIDX_W-1:0] CFG_TOL    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_EXCESS = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_UPT    = 2'd2;

	localparam logic [TOL_W-1:0] TOL_RST = 6'd25;
	localparam logic [EX_W-1:0]  EX_RST  = 8'd100;
	localparam logic [UPT_W-1:0] UPT_RST = 8'd50;

	// Window arithmetic widths
	localparam int D_W     = 10;   // nominal plus or minus excess, up to 791 us
	localparam int F_W     = 8;    // 100 +/- tolerance
	localparam int NUM_W   = 17;   // d * factor, below 2^17
	localparam int DEN_W   = 15;   // 100 * us_per_tick
	localparam int WIN_W   = 11;   // window limits stay below 2^11
	localparam logic [F_W-1:0] PCT = 8'd100;

	// Window table entries
	localparam int NUM_WIN = 7;
	localparam int ENT_W   = 3;
	localparam logic [ENT_W-1:0] W_HDR_MARK  = 3'd0;
	localparam logic [ENT_W-1:0] W_BIT_MARK  = 3'd1;
	localparam logic [ENT_W-1:0] W_HDR_SPACE = 3'd2;
	localparam logic [ENT_W-1:0] W_SYM00     = 3'd3;
	localparam logic [ENT_W-1:0] W_SYM01     = 3'd4;
	localparam logic [ENT_W-1:0] W_SYM10     = 3'd5;
	localparam logic [ENT_W-1:0] W_SYM11     = 3'd6;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HDR_MARK  = 3'd1,
		ST_HDR_SPACE = 3'd2,
		ST_BIT_MARK  = 3'd3,
		ST_BIT_SPACE = 3'd4,
		ST_STOP_MARK = 3'd5
	} status_t;

	typedef struct packed {
		logic [TOL_W-1:0] tol;
		logic [EX_W-1:0]  excess;
		logic [UPT_W-1:0] upt;
	} cfg_t;

	typedef logic [NUM_WIN-1:0][WIN_W-1:0] win_arr_t;

	// Nominal time of each table entry in microseconds
	function automatic logic [D_W-1:0] nominal_us(input logic [ENT_W-1:0] ent);
		logic [D_W-1:0] r;
		case (ent)
			W_HDR_MARK:  r = 10'd425;
			W_BIT_MARK:  r = 10'd150;
			W_HDR_SPACE: r = 10'd260;
			W_SYM00:     r = 10'd294;
			W_SYM01:     r = 10'd450;
			W_SYM10:     r = 10'd610;
			W_SYM11:     r = 10'd791;
			default:     r = '0;
		endcase
		return r;
	endfunction

	function automatic logic is_mark(input logic [ENT_W-1:0] ent);
		return (ent == W_HDR_MARK) || (ent == W_BIT_MARK);
	endfunction

endpackage

// ===== hdl/rcmm_win_calc.sv =====
// Window table builder: for each entry computes
// lo = floor(d*(100-t)/(100*u)) and hi = floor(d*(100+t)/(100*u)) + 1
// with one restoring divider, one quotient bit per cycle.
module rcmm_win_calc (
	input  logic              clk,
	input  logic              arst_n,
	input  rcmm_pkg::cfg_t    cfg,
	input  logic              restart,
	output logic              busy,
	output rcmm_pkg::win_arr_t win_lo,
	output rcmm_pkg::win_arr_t win_hi
);
	import rcmm_pkg::*;

	localparam int NUM_JOBS = 2 * NUM_WIN;
	localparam int JOB_W    = $clog2(NUM_JOBS);
	localparam int STEP_W   = $clog2(NUM_W + 1);
	localparam logic [JOB_W-1:0]  JOB_LAST  = JOB_W'(NUM_JOBS - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W);

	logic              busy_q;
	logic [JOB_W-1:0]  job_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	win_arr_t          lo_q;
	win_arr_t          hi_q;

	logic [ENT_W-1:0]     ent;
	logic                 side;
	logic [D_W-1:0]       nom;
	logic [D_W-1:0]       dur;
	logic [F_W-1:0]       factor;
	logic [D_W+F_W-1:0]   prod;
	logic [UPT_W-1:0]     upt_eff;
	logic [DEN_W-1:0]     den;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 ge;
	logic [DEN_W-1:0]     rem_nx;
	logic [NUM_W-1:0]     quo_nx;
	logic [WIN_W-1:0]     q_res;

	// Numerator and denominator for the current entry
	always_comb begin
		ent  = job_q[JOB_W-1:1];
		side = job_q[0];
		nom  = nominal_us(ent);
		if (is_mark(ent)) begin
			dur = nom + D_W'(cfg.excess);
		end else if (nom > D_W'(cfg.excess)) begin
			dur = nom - D_W'(cfg.excess);
		end else begin
			dur = '0;
		end
		factor  = side ? (PCT + F_W'(cfg.tol)) : (PCT - F_W'(cfg.tol));
		prod    = (D_W+F_W)'(dur) * (D_W+F_W)'(factor);
		upt_eff = (cfg.upt == '0) ? UPT_W'(1) : cfg.upt;
		den     = DEN_W'(upt_eff) * DEN_W'(PCT);
	end

	// One restoring division step
	always_comb begin
		trial  = {rem_q, quo_q[NUM_W-1]};
		diff   = trial - {1'b0, den};
		ge     = (trial >= {1'b0, den});
		rem_nx = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		quo_nx = {quo_q[NUM_W-2:0], ge};
		q_res  = quo_nx[WIN_W-1:0];
	end

	// Sequence the jobs: load, then one step per quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			job_q  <= '0;
			step_q <= '0;
		end else if (restart) begin
			busy_q <= 1'b1;
			job_q  <= '0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_LAST) begin
				step_q <= '0;
				if (job_q == JOB_LAST) begin
					busy_q <= 1'b0;
				end else begin
					job_q <= job_q + 1'b1;
				end
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Divider datapath and table write
	always_ff @(posedge clk) begin
		if (busy_q && !restart) begin
			if (step_q == '0) begin
				rem_q <= '0;
				quo_q <= prod[NUM_W-1:0];
			end else begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (step_q == STEP_LAST) begin
					if (side) begin
						hi_q[ent] <= q_res + 1'b1;
					end else begin
						lo_q[ent] <= q_res;
					end
				end
			end
		end
	end

	assign busy   = busy_q;
	assign win_lo = lo_q;
	assign win_hi = hi_q;

endmodule

// ===== hdl/rcmm_ir_frame_decoder_unit.sv =====
// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------
// in        in_valid / in_ready    duration_ticks[15:0], frame_start
// out       out_valid / out_ready  status[2:0], value[31:0]
// cfg       cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[7:0]
//
// One duration per cycle unless the table build or a waiting result holds
// in_ready low; a result lands in the output register at the edge that
// takes its item from the input register. The match windows sit in a table
// built by a bit-serial divider that computes its 14 limits after reset and
// after every register write, with in_ready low meanwhile. cfg_ready is always high.
// A waiting result stalls only the input register; an empty one still
// takes a transfer.
`include "rcmm_ir_frame_decoder_unit_macros.svh"

module rcmm_ir_frame_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rcmm_pkg::TICK_W-1:0]       duration_ticks,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic [rcmm_pkg::VALUE_W-1:0]      value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcmm_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [rcmm_pkg::CDATA_W-1:0]      cfg_data
);
	import rcmm_pkg::*;

	localparam logic [POS_W-1:0] STOP_POS = POS_W'(STOP_IDX);

	cfg_t     cfg_q;
	logic     cfg_fire;
	logic     win_busy;
	win_arr_t win_lo;
	win_arr_t win_hi;

	logic              valid_s1;
	logic [TICK_W-1:0] ticks_s1;
	logic              start_s1;
	logic              in_fire;
	logic              s1_go;

	logic               active_q;
	logic [POS_W-1:0]   pos_q;
	logic [VALUE_W-1:0] shift_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [VALUE_W-1:0] value_q;

	logic [NUM_WIN-1:0] hit;
	logic               cur_active;
	logic [POS_W-1:0]   cur_pos;
	logic [VALUE_W-1:0] cur_shift;
	logic [1:0]         sym;
	logic               sym_ok;
	logic               res_valid;
	status_t            res_status;
	logic [VALUE_W-1:0] res_value;
	logic               nxt_active;
	logic [POS_W-1:0]   nxt_pos;
	logic [VALUE_W-1:0] nxt_shift;

	// Configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tol    <= TOL_RST;
			cfg_q.excess <= EX_RST;
			cfg_q.upt    <= UPT_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_TOL:    cfg_q.tol    <= cfg_data[TOL_W-1:0];
				CFG_EXCESS: cfg_q.excess <= cfg_data[EX_W-1:0];
				CFG_UPT:    cfg_q.upt    <= cfg_data[UPT_W-1:0];
				default:    ;
			endcase
		end
	end

	rcmm_win_calc u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.restart (cfg_fire),
		.busy    (win_busy),
		.win_lo  (win_lo),
		.win_hi  (win_hi)
	);

	// Input register
	assign s1_go    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !win_busy && (!valid_s1 || s1_go);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ticks_s1 <= duration_ticks;
			start_s1 <= frame_start;
		end
	end

	// Window compares
	always_comb begin
		for (int i = 0; i < NUM_WIN; i++) begin
			hit[i] = (ticks_s1 >= TICK_W'(win_lo[i])) && (ticks_s1 <= TICK_W'(win_hi[i]));
		end
	end

	// Classify a bit space, shortest symbol first
	always_comb begin
		sym_ok = 1'b1;
		if (hit[W_SYM00]) begin
			sym = 2'd0;
		end else if (hit[W_SYM01]) begin
			sym = 2'd1;
		end else if (hit[W_SYM10]) begin
			sym = 2'd2;
		end else if (hit[W_SYM11]) begin
			sym = 2'd3;
		end else begin
			sym    = 2'd0;
			sym_ok = 1'b0;
		end
	end

	// Frame decode for the item in the input register
	always_comb begin
		cur_active = start_s1 || active_q;
		cur_pos    = start_s1 ? '0 : pos_q;
		cur_shift  = start_s1 ? '0 : shift_q;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_value  = '0;
		nxt_active = cur_active;
		nxt_pos    = cur_pos;
		nxt_shift  = cur_shift;
		if (cur_active) begin
			if (cur_pos == '0) begin
				if (hit[W_HDR_MARK]) begin
					nxt_pos = cur_pos + 1'b1;
				end else begin
					res_valid  = 1'b1;
					res_status = ST_HDR_MARK;
				end
			end else if (cur_pos == POS_W'(1)) begin
				if (hit[W_HDR_SPACE]) begin
					nxt_pos = cur_pos + 1'b1;
				end else begin
					res_valid  = 1'b1;
					res_status = ST_HDR_SPACE;
				end
			end else if (cur_pos >= STOP_POS) begin
				res_valid = 1'b1;
				if (hit[W_BIT_MARK]) begin
					res_status = ST_OK;
					res_value  = cur_shift;
				end else begin
					res_status = ST_STOP_MARK;
				end
			end else if (!cur_pos[0]) begin
				if (hit[W_BIT_MARK]) begin
					nxt_pos = cur_pos + 1'b1;
				end else begin
					res_valid  = 1'b1;
					res_status = ST_BIT_MARK;
				end
			end else begin
				if (sym_ok) begin
					nxt_shift = {cur_shift[VALUE_W-3:0], sym};
					nxt_pos   = cur_pos + 1'b1;
				end else begin
					res_valid  = 1'b1;
					res_status = ST_BIT_SPACE;
				end
			end
			// Any result ends the frame
			if (res_valid) begin
				nxt_active = 1'b0;
				nxt_pos    = '0;
				nxt_shift  = '0;
			end
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			shift_q  <= '0;
		end else if (s1_go) begin
			active_q <= nxt_active;
			pos_q    <= nxt_pos;
			shift_q  <= nxt_shift;
		end
	end

	// Output register: load a new result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			status_q <= res_status;
			value_q  <= res_value;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;

	// Checks
	`RCMM_ASSERT_IMPL(a_no_take_busy, clk, arst_n, in_valid && in_ready, !win_busy)
	`RCMM_ASSERT_IMPL(a_fail_zero, clk, arst_n, out_valid && (status != ST_OK), value == '0)
	`RCMM_ASSERT_NEXT(a_result_ends, clk, arst_n, s1_go && res_valid, !active_q && (pos_q == '0))
	`RCMM_ASSERT_IMPL(a_pos_range, clk, arst_n, 1'b1, pos_q <= STOP_POS)

endmodule

// ===== dv/rcmm_ir_frame_decoder_unit_tb.sv =====
module rcmm_ir_frame_decoder_unit_tb;
	import rcmm_pkg::*;

	// Nominal pulse times in microseconds
	localparam int unsigned HDR_MARK_US  = 425;
	localparam int unsigned HDR_SPACE_US = 260;
	localparam int unsigned BIT_MARK_US  = 150;
	localparam int unsigned SYM00_US     = 294;
	localparam int unsigned SYM01_US     = 450;
	localparam int unsigned SYM10_US     = 610;
	localparam int unsigned SYM11_US     = 791;
	localparam int unsigned SYM_NONE     = 4;

	// Register index with no register behind it
	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 900;
	localparam int PHASE_ITEMS  = 150;

	// Ways to spoil one pulse of a frame
	typedef enum {
		FLAW_NONE,
		FLAW_BELOW,
		FLAW_ABOVE,
		FLAW_WILD,
		FLAW_HUGE,
		FLAW_RESTART
	} flaw_t;

	typedef struct {
		status_t     st;
		logic [31:0] word;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [TICK_W-1:0]    duration_ticks;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           status;
	logic [VALUE_W-1:0]   value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CIDX_W-1:0]    cfg_index;
	logic [CDATA_W-1:0]   cfg_data;

	// Decoder shadow state and register copies
	bit          dec_active;
	int          dec_pos;
	logic [31:0] dec_shift;
	logic [5:0]  tol_reg;
	logic [7:0]  excess_reg;
	logic [7:0]  upt_reg;

	outcome_t expected_outcomes[$];
	int       live_items;
	int       mismatches;
	bit       steady;

	rcmm_ir_frame_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.duration_ticks (duration_ticks),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.value          (value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned symbol_us(input int unsigned sym);
		case (sym)
			0:       return SYM00_US;
			1:       return SYM01_US;
			2:       return SYM10_US;
			default: return SYM11_US;
		endcase
	endfunction

	// Marks grow by the excess, spaces shrink by it (floored at zero)
	function automatic int unsigned timed_us(input int unsigned nom, input bit mark);
		if (mark)
			return nom + excess_reg;
		return (nom > excess_reg) ? nom - excess_reg : 0;
	endfunction

	// Tick window for a time in us under the current tolerance and tick size
	function automatic void match_window(input int unsigned d_us, output int unsigned lo,
			output int unsigned hi);
		longint unsigned d;
		longint unsigned pct;
		longint unsigned den;
		d   = d_us;
		pct = tol_reg;
		den = 100 * ((upt_reg == 0) ? 1 : upt_reg);
		lo  = 32'((d * (100 - pct)) / den);
		hi  = 32'((d * (100 + pct)) / den + 1);
	endfunction

	function automatic bit fits(input logic [15:0] t, input int unsigned nom, input bit mark);
		int unsigned lo;
		int unsigned hi;
		match_window(timed_us(nom, mark), lo, hi);
		return (t >= lo) && (t <= hi);
	endfunction

	// Advance the shadow decoder by one pulse and queue any result it gives
	function automatic void decode_pulse(input logic [15:0] t, input bit start);
		outcome_t    o;
		bit          done;
		int unsigned sym;
		o.st   = ST_OK;
		o.word = '0;
		done   = 1'b0;
		if (start) begin
			dec_active = 1'b1;
			dec_pos    = 0;
			dec_shift  = '0;
		end
		if (!dec_active)
			return;
		live_items++;
		if (dec_pos == 0) begin
			if (!fits(t, HDR_MARK_US, 1'b1)) begin
				o.st = ST_HDR_MARK;
				done = 1'b1;
			end else
				dec_pos = 1;
		end else if (dec_pos == 1) begin
			if (!fits(t, HDR_SPACE_US, 1'b0)) begin
				o.st = ST_HDR_SPACE;
				done = 1'b1;
			end else
				dec_pos = 2;
		end else if (dec_pos >= STOP_IDX) begin
			o.st = fits(t, BIT_MARK_US, 1'b1) ? ST_OK : ST_STOP_MARK;
			done = 1'b1;
		end else if (((dec_pos - 2) % 2) == 0) begin
			if (!fits(t, BIT_MARK_US, 1'b1)) begin
				o.st = ST_BIT_MARK;
				done = 1'b1;
			end else
				dec_pos++;
		end else begin
			// Lowest symbol whose window holds the space wins
			sym = SYM_NONE;
			for (int s = 3; s >= 0; s--)
				if (fits(t, symbol_us(s), 1'b0))
					sym = s;
			if (sym == SYM_NONE) begin
				o.st = ST_BIT_SPACE;
				done = 1'b1;
			end else begin
				dec_shift = {dec_shift[29:0], sym[1:0]};
				dec_pos++;
			end
		end
		if (done) begin
			if (o.st == ST_OK)
				o.word = dec_shift;
			expected_outcomes.push_back(o);
			dec_active = 1'b0;
			dec_pos    = 0;
			dec_shift  = '0;
		end
	endfunction

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: status %0d value %h",
					$time, status, value);
			end else begin
				e = expected_outcomes.pop_front();
				if (status !== e.st) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
				end
				if (value !== e.word) begin
					mismatches++;
					$display("%0t: value expected %h actual %h", $time, e.word, value);
				end
			end
		end
	end

	// Result side: stall a random number of cycles before each transfer
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(5, 0);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Offer one pulse after a random gap; valid stays high for the next caller
	task automatic send_pulse(input logic [15:0] ticks, input bit start);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(5, 0);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		duration_ticks <= ticks;
		frame_start    <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_pulse(ticks, start);
	endtask

	// Drop valid and wait until the block has nothing left in flight
	task automatic drain_decoder();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_TOL:    tol_reg    = data[5:0];
			CFG_EXCESS: excess_reg = data;
			CFG_UPT:    upt_reg    = data;
			default:    ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [7:0] tol, input logic [7:0] ex,
			input logic [7:0] upt);
		drain_decoder();
		write_reg(CFG_TOL, tol);
		write_reg(CFG_EXCESS, ex);
		write_reg(CFG_UPT, upt);
	endtask

	// Pick a pulse length inside the window, on an edge, or spoiled
	function automatic logic [15:0] pick_ticks(input int unsigned nom, input bit mark,
			input flaw_t flaw);
		int unsigned lo;
		int unsigned hi;
		int unsigned r;
		match_window(timed_us(nom, mark), lo, hi);
		case (flaw)
			FLAW_BELOW: return 16'((lo > 0) ? lo - 1 : hi + 1);
			FLAW_ABOVE: return 16'(hi + 1);
			FLAW_WILD:  return 16'($urandom_range(16'hFFFF, 0));
			FLAW_HUGE:  return 16'hFFFF;
			default: begin
				r = $urandom_range(9, 0);
				if (r == 0)
					return 16'(lo);
				if (r == 1)
					return 16'(hi);
				return 16'($urandom_range(hi, lo));
			end
		endcase
	endfunction

	// Send a frame carrying word; spoil the pulse at flaw_at and stop there
	task automatic send_frame(input logic [31:0] word, input int flaw_at, input flaw_t kind);
		flaw_t f;
		int    p;
		for (int k = 0; k <= STOP_IDX; k++) begin
			f = (k == flaw_at) ? kind : FLAW_NONE;
			if (f == FLAW_RESTART) begin
				send_pulse(pick_ticks(HDR_MARK_US, 1'b1, FLAW_NONE), 1'b1);
				return;
			end
			if (k == 0)
				send_pulse(pick_ticks(HDR_MARK_US, 1'b1, f), 1'b1);
			else if (k == 1)
				send_pulse(pick_ticks(HDR_SPACE_US, 1'b0, f), 1'b0);
			else if (k % 2 == 0)
				send_pulse(pick_ticks(BIT_MARK_US, 1'b1, f), 1'b0);
			else begin
				p = (k - 3) / 2;
				send_pulse(pick_ticks(symbol_us(word[31 - 2 * p -: 2]), 1'b0, f), 1'b0);
			end
			if (f != FLAW_NONE)
				return;
		end
	endtask

	function automatic flaw_t random_flaw();
		case ($urandom_range(4, 0))
			0:       return FLAW_BELOW;
			1:       return FLAW_ABOVE;
			2:       return FLAW_WILD;
			3:       return FLAW_HUGE;
			default: return FLAW_RESTART;
		endcase
	endfunction

	// Idle pulses, then a failure at the header mark, header space, first bit mark and first symbol
	task automatic test_status_codes();
		steady = 1'b0;
		send_pulse(16'h0000, 1'b0);
		send_pulse(16'hFFFF, 1'b0);
		send_pulse(16'h0000, 1'b1);
		send_pulse(16'hFFFF, 1'b1);
		send_frame($urandom(), 1, FLAW_ABOVE);
		send_frame($urandom(), 2, FLAW_BELOW);
		send_frame($urandom(), 3, FLAW_HUGE);
		drain_decoder();
	endtask

	// Whole frames with fixed symbol patterns, then a bad stop mark
	task automatic test_frame_values();
		steady = 1'b1;
		send_frame(32'h0000_0000, -1, FLAW_NONE);
		steady = 1'b0;
		send_frame(32'hFFFF_FFFF, -1, FLAW_NONE);
		send_frame(32'hAAAA_AAAA, -1, FLAW_NONE);
		send_frame(32'h1B1B_E4E4, -1, FLAW_NONE);
		send_frame($urandom(), STOP_IDX, FLAW_HUGE);
		drain_decoder();
	endtask

	// Drop a frame in progress with a new header, then finish a clean one
	task automatic test_restart();
		send_frame($urandom(), 20, FLAW_RESTART);
		send_frame($urandom(), STOP_IDX, FLAW_RESTART);
		send_frame($urandom(), -1, FLAW_NONE);
		drain_decoder();
	endtask

	// Corner settings: tight and wide windows, zero tick size, spare index
	task automatic test_config_extremes();
		apply_settings(8'd0, 8'd0, 8'd1);
		send_frame($urandom(), -1, FLAW_NONE);
		apply_settings(8'd50, 8'd255, 8'd255);
		send_frame($urandom(), -1, FLAW_NONE);
		send_frame($urandom(), $urandom_range(STOP_IDX, 0), random_flaw());
		apply_settings(8'd63, 8'd0, 8'd0);
		send_frame($urandom(), -1, FLAW_NONE);
		apply_settings(8'd0, 8'd255, 8'd255);
		send_frame($urandom(), -1, FLAW_NONE);
		send_frame($urandom(), $urandom_range(STOP_IDX, 0), random_flaw());
		apply_settings(8'd50, 8'd0, 8'd1);
		send_frame($urandom(), -1, FLAW_NONE);
		apply_settings(8'hFF, 8'd128, 8'd100);
		write_reg(CFG_SPARE, 8'hA5);
		send_frame($urandom(), -1, FLAW_NONE);
		send_frame($urandom(), $urandom_range(STOP_IDX, 0), random_flaw());
		apply_settings(8'd25, 8'd100, 8'd50);
		send_frame($urandom(), -1, FLAW_NONE);
		drain_decoder();
	endtask

	task automatic random_settings();
		logic [7:0] tol;
		logic [7:0] ex;
		logic [7:0] upt;
		case ($urandom_range(4, 0))
			0:       tol = 8'd0;
			1:       tol = 8'd50;
			2:       tol = 8'd63;
			3:       tol = 8'($urandom_range(63, 0));
			default: tol = 8'($urandom_range(255, 0));
		endcase
		case ($urandom_range(3, 0))
			0:       ex = 8'd0;
			1:       ex = 8'd255;
			default: ex = 8'($urandom_range(255, 0));
		endcase
		case ($urandom_range(4, 0))
			0:       upt = 8'd0;
			1:       upt = 8'd1;
			2:       upt = 8'd255;
			default: upt = 8'($urandom_range(255, 1));
		endcase
		apply_settings(tol, ex, upt);
		if ($urandom_range(4, 0) == 0)
			write_reg(CFG_SPARE, 8'($urandom_range(255, 0)));
	endtask

	// Mostly clean frames, some spoiled ones and loose pulses, new settings per phase
	task automatic test_random_traffic();
		int base;
		int next_phase;
		int unsigned r;
		base       = live_items;
		next_phase = base + PHASE_ITEMS;
		while (live_items < base + RANDOM_ITEMS) begin
			if (live_items >= next_phase) begin
				random_settings();
				next_phase = live_items + PHASE_ITEMS;
			end
			steady = ($urandom_range(3, 0) == 0);
			r = $urandom_range(99, 0);
			if (r < 60)
				send_frame($urandom(), -1, FLAW_NONE);
			else if (r < 85)
				send_frame($urandom(), $urandom_range(STOP_IDX, 0), random_flaw());
			else
				send_pulse(16'($urandom_range(16'hFFFF, 0)), $urandom_range(3, 0) == 0);
		end
		steady = 1'b0;
		drain_decoder();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		duration_ticks = '0;
		frame_start    = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_TOL;
		cfg_data       = '0;
		dec_active     = 1'b0;
		dec_pos        = 0;
		dec_shift      = '0;
		tol_reg        = TOL_RST;
		excess_reg     = EX_RST;
		upt_reg        = UPT_RST;
		live_items     = 0;
		mismatches     = 0;
		steady         = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_status_codes();
		test_frame_values();
		test_restart();
		test_config_extremes();
		test_random_traffic();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
